### hdl/aaeu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aaeu_pkg
// Types and opcodes shared by the accumulator ALU execute unit and its datapath.
// ----------------------------------------------------------------------------
package aaeu_pkg;

    // opcode byte values
    typedef enum logic [7:0] {
        OP_ADD     = 8'h00,
        OP_SUB     = 8'h01,
        OP_INC     = 8'h02,
        OP_DEC     = 8'h03,
        OP_LDA     = 8'h09,
        OP_XTA     = 8'h0C,
        OP_ATX     = 8'h0D,
        OP_LDX     = 8'h0E,
        OP_XSRA    = 8'h19,
        OP_XSLA    = 8'h1A,
        OP_ASRX    = 8'h1B,
        OP_ASLX    = 8'h1C,
        OP_AND     = 8'h1D,
        OP_OR      = 8'h1E,
        OP_XOR     = 8'h1F,
        OP_CLF     = 8'h20,
        OP_CLC     = 8'h21,
        OP_CLN     = 8'h22,
        OP_CLZ     = 8'h23,
        OP_XXA     = 8'h24,
        OP_ADDF    = 8'h28,
        OP_SUBF    = 8'h29,
        OP_NOTA    = 8'h30,
        OP_NOTX    = 8'h31,
        OP_NEG     = 8'h32,
        OP_SWAP    = 8'h33,
        OP_ADC     = 8'h34,
        OP_SBC     = 8'h35,
        OP_ROL     = 8'h38,
        OP_ROR     = 8'h39,
        OP_ASL     = 8'h3A,
        OP_ASR     = 8'h3B,
        OP_CLR_ALL = 8'h43,
        OP_BIN2BCD = 8'h44,
        OP_BCD2BIN = 8'h45,
        OP_BCD_ADD = 8'h46,
        OP_BCD_SUB = 8'h47
    } op_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    // architectural state of the unit
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] idx;
        flags_t     flags;
    } arch_t;

    typedef struct packed {
        logic [7:0] action;
        logic [7:0] operand;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] acc_out;
        logic [7:0] index_out;
        logic       neg_flag;
        logic       zero_flag;
        logic       carry_flag;
        logic       ovf_flag;
    } out_beat_t;

endpackage
`default_nettype wire

### hdl/aaeu_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aaeu_alu
// Next-state logic: one opcode applied to A, X and the N, Z, C, V flags.
// ----------------------------------------------------------------------------
module aaeu_alu (
    input  wire aaeu_pkg::in_beat_t beat,
    input  wire aaeu_pkg::arch_t    cur,
    output aaeu_pkg::arch_t         nxt
);
    import aaeu_pkg::*;

    localparam logic [6:0] BcdMax = 7'd99;

    function automatic flags_t put_nz(input flags_t f, input logic [7:0] r);
        flags_t o;
        o   = f;
        o.n = r[7];
        o.z = (r == 8'd0);
        return o;
    endfunction

    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] opd;
    flags_t     f;

    assign a   = cur.acc;
    assign x   = cur.idx;
    assign opd = beat.operand;
    assign f   = cur.flags;

    // binary adders and subtractors
    logic [8:0] add_sum;
    logic [8:0] sub_diff;
    logic [8:0] adc_sum;
    logic [9:0] sbc_diff;
    logic [7:0] neg_val;
    logic       add_v;
    logic       sub_v;
    logic       adc_v;
    logic       sbc_v;

    assign add_sum  = {1'b0, a} + {1'b0, x};
    assign sub_diff = {1'b0, a} - {1'b0, x};
    assign adc_sum  = {1'b0, a} + {1'b0, opd} + {8'd0, f.c};
    assign sbc_diff = {2'b00, a} - {2'b00, opd} - {9'd0, ~f.c};
    assign neg_val  = 8'd0 - a;
    assign add_v    = ~(a[7] ^ x[7]) & (a[7] ^ add_sum[7]);
    assign sub_v    = (a[7] ^ x[7]) & (a[7] ^ sub_diff[7]);
    assign adc_v    = ~(a[7] ^ opd[7]) & (a[7] ^ adc_sum[7]);
    assign sbc_v    = (a[7] ^ opd[7]) & (a[7] ^ sbc_diff[7]);

    // binary to bcd, tens by reciprocal multiply (exact below 1029)
    logic        b2d_cy;
    logic [6:0]  b2d_val;
    logic [14:0] b2d_prod;
    logic [3:0]  b2d_tens;
    logic [6:0]  b2d_tens10;
    logic [6:0]  b2d_ones;
    logic [7:0]  b2d_res;

    assign b2d_cy     = (a > {1'b0, BcdMax});
    assign b2d_val    = b2d_cy ? BcdMax : a[6:0];
    assign b2d_prod   = {8'd0, b2d_val} * 15'd205;
    assign b2d_tens   = b2d_prod[14:11];
    assign b2d_tens10 = {b2d_tens, 3'b000} + {2'b00, b2d_tens, 1'b0};
    assign b2d_ones   = b2d_val - b2d_tens10;
    assign b2d_res    = {b2d_tens, b2d_ones[3:0]};

    // bcd to binary with digit clamp
    logic       d2b_hi_bad;
    logic       d2b_lo_bad;
    logic [3:0] d2b_hi;
    logic [3:0] d2b_lo;
    logic [6:0] d2b_res;

    assign d2b_hi_bad = (a[7:4] > 4'd9);
    assign d2b_lo_bad = (a[3:0] > 4'd9);
    assign d2b_hi     = d2b_hi_bad ? 4'd9 : a[7:4];
    assign d2b_lo     = d2b_lo_bad ? 4'd9 : a[3:0];
    assign d2b_res    = {d2b_hi, 3'b000} + {2'b00, d2b_hi, 1'b0} + {3'b000, d2b_lo};

    // clamping bcd add
    logic [4:0] badd_lo;
    logic       badd_lc;
    logic [4:0] badd_lo_fix;
    logic [4:0] badd_hi;
    logic       badd_ovf;
    logic [7:0] badd_res;

    assign badd_lo     = {1'b0, a[3:0]} + {1'b0, x[3:0]};
    assign badd_lc     = (badd_lo > 5'd9);
    assign badd_lo_fix = badd_lc ? (badd_lo - 5'd10) : badd_lo;
    assign badd_hi     = {1'b0, a[7:4]} + {1'b0, x[7:4]} + {4'd0, badd_lc};
    assign badd_ovf    = (badd_hi > 5'd9);
    assign badd_res    = {(badd_ovf ? 4'd9 : badd_hi[3:0]), badd_lo_fix[3:0]};

    // clamping bcd subtract
    logic [4:0] bsub_lo;
    logic       bsub_lb;
    logic [4:0] bsub_lo_fix;
    logic [5:0] bsub_hi;
    logic       bsub_unf;
    logic [7:0] bsub_res;

    assign bsub_lo     = {1'b0, a[3:0]} - {1'b0, x[3:0]};
    assign bsub_lb     = bsub_lo[4];
    assign bsub_lo_fix = bsub_lb ? (bsub_lo + 5'd10) : bsub_lo;
    assign bsub_hi     = {2'b00, a[7:4]} - {2'b00, x[7:4]} - {5'd0, bsub_lb};
    assign bsub_unf    = bsub_hi[5];
    assign bsub_res    = {(bsub_unf ? 4'd0 : bsub_hi[3:0]), bsub_lo_fix[3:0]};

    always_comb begin
        nxt = cur;
        unique case (op_t'(beat.action))
            OP_ADD: begin
                nxt.acc     = add_sum[7:0];
                nxt.flags   = put_nz(f, add_sum[7:0]);
                nxt.flags.c = add_sum[8];
                nxt.flags.v = add_v;
            end
            OP_SUB: begin
                nxt.acc     = sub_diff[7:0];
                nxt.flags   = put_nz(f, sub_diff[7:0]);
                nxt.flags.c = ~sub_diff[8];
                nxt.flags.v = sub_v;
            end
            OP_INC: begin
                nxt.acc   = a + 8'd1;
                nxt.flags = put_nz(f, a + 8'd1);
            end
            OP_DEC: begin
                nxt.acc   = a - 8'd1;
                nxt.flags = put_nz(f, a - 8'd1);
            end
            OP_LDA: begin
                nxt.acc   = opd;
                nxt.flags = put_nz(f, opd);
            end
            OP_XTA: begin
                nxt.acc   = x;
                nxt.flags = put_nz(f, x);
            end
            OP_ATX: begin
                nxt.idx   = a;
                nxt.flags = put_nz(f, a);
            end
            OP_LDX: begin
                nxt.idx   = opd;
                nxt.flags = put_nz(f, opd);
            end
            OP_XSRA: begin
                nxt.acc     = {1'b0, x[7:1]};
                nxt.flags   = put_nz(f, {1'b0, x[7:1]});
                nxt.flags.c = x[0];
            end
            OP_XSLA: begin
                nxt.acc     = {x[6:0], 1'b0};
                nxt.flags   = put_nz(f, {x[6:0], 1'b0});
                nxt.flags.c = x[7];
            end
            OP_ASRX: begin
                nxt.idx     = {1'b0, a[7:1]};
                nxt.flags   = put_nz(f, {1'b0, a[7:1]});
                nxt.flags.c = a[0];
            end
            OP_ASLX: begin
                nxt.idx     = {a[6:0], 1'b0};
                nxt.flags   = put_nz(f, {a[6:0], 1'b0});
                nxt.flags.c = a[7];
            end
            OP_AND: begin
                nxt.acc   = a & x;
                nxt.flags = put_nz(f, a & x);
            end
            OP_OR: begin
                nxt.acc   = a | x;
                nxt.flags = put_nz(f, a | x);
            end
            OP_XOR: begin
                nxt.acc   = a ^ x;
                nxt.flags = put_nz(f, a ^ x);
            end
            OP_CLF: begin
                nxt.flags = '0;
            end
            OP_CLC: begin
                nxt.flags.c = 1'b0;
            end
            OP_CLN: begin
                nxt.flags.n = 1'b0;
            end
            OP_CLZ: begin
                nxt.flags.z = 1'b0;
            end
            OP_XXA: begin
                nxt.idx   = x ^ a;
                nxt.flags = put_nz(f, x ^ a);
            end
            OP_ADDF: begin
                nxt.flags   = put_nz(f, add_sum[7:0]);
                nxt.flags.c = add_sum[8];
                nxt.flags.v = add_v;
            end
            OP_SUBF: begin
                nxt.flags   = put_nz(f, sub_diff[7:0]);
                nxt.flags.c = ~sub_diff[8];
                nxt.flags.v = sub_v;
            end
            OP_NOTA: begin
                nxt.acc   = ~a;
                nxt.flags = put_nz(f, ~a);
            end
            OP_NOTX: begin
                nxt.idx   = ~x;
                nxt.flags = put_nz(f, ~x);
            end
            OP_NEG: begin
                nxt.acc     = neg_val;
                nxt.flags   = put_nz(f, neg_val);
                nxt.flags.c = (neg_val != 8'd0);
                nxt.flags.v = a[7] ^ neg_val[7];
            end
            OP_SWAP: begin
                nxt.acc = x;
                nxt.idx = a;
            end
            OP_ADC: begin
                nxt.acc     = adc_sum[7:0];
                nxt.flags   = put_nz(f, adc_sum[7:0]);
                nxt.flags.c = adc_sum[8];
                nxt.flags.v = adc_v;
            end
            OP_SBC: begin
                nxt.acc     = sbc_diff[7:0];
                nxt.flags   = put_nz(f, sbc_diff[7:0]);
                nxt.flags.c = ~sbc_diff[9];
                nxt.flags.v = sbc_v;
            end
            OP_ROL: begin
                nxt.acc     = {a[6:0], f.c};
                nxt.flags   = put_nz(f, {a[6:0], f.c});
                nxt.flags.c = a[7];
            end
            OP_ROR: begin
                nxt.acc     = {f.c, a[7:1]};
                nxt.flags   = put_nz(f, {f.c, a[7:1]});
                nxt.flags.c = a[0];
            end
            OP_ASL: begin
                nxt.acc     = {a[6:0], 1'b0};
                nxt.flags   = put_nz(f, {a[6:0], 1'b0});
                nxt.flags.c = a[7];
            end
            OP_ASR: begin
                nxt.acc     = {a[7], a[7:1]};
                nxt.flags   = put_nz(f, {a[7], a[7:1]});
                nxt.flags.c = a[0];
            end
            OP_CLR_ALL: begin
                nxt = '0;
            end
            OP_BIN2BCD: begin
                nxt.acc     = b2d_res;
                nxt.flags.z = (b2d_res == 8'd0);
                nxt.flags.c = b2d_cy;
            end
            OP_BCD2BIN: begin
                nxt.acc     = {1'b0, d2b_res};
                nxt.flags.z = (d2b_res == 7'd0);
                nxt.flags.c = d2b_hi_bad | d2b_lo_bad;
            end
            OP_BCD_ADD: begin
                nxt.acc     = badd_res;
                nxt.flags.z = (badd_res == 8'd0);
                nxt.flags.c = badd_ovf;
                nxt.flags.n = badd_res[7];
                nxt.flags.v = badd_ovf;
            end
            OP_BCD_SUB: begin
                nxt.acc     = bsub_res;
                nxt.flags.z = (bsub_res == 8'd0);
                nxt.flags.c = ~bsub_unf;
                nxt.flags.n = bsub_res[7];
                nxt.flags.v = bsub_unf;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/accumulator_alu_execute_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_alu_execute_unit
// Register and flag execute stage of an 8-bit accumulator CPU.
// ----------------------------------------------------------------------------
// Use:
//   s_valid/s_ready/s_payload carry one opcode beat (action, operand).
//   m_valid/m_ready/m_payload return one result beat per opcode: A, X and
//   the N, Z, C, V flags as they stand after that opcode.
//   Unknown opcodes return the state unchanged.
// Timing:
//   a taken beat sits in the input register, goes through the
//   single-pass ALU and lands in the result register as soon as that
//   register is free, which raises m_valid. One beat per cycle is
//   sustained: the input register and the result register each
//   advance every cycle while m_ready stays high.
//   A, X and the flags update at the same edge as the result register,
//   so the next opcode always sees the state left by the one before.
// Reset (aresetn low, synchronous):
//   A, X and all flags clear; both stage valids drop.
// Stall:
//   with m_ready low the result beat holds, one more beat is held in the
//   input register, then s_ready drops until the receiver takes a beat.
// ----------------------------------------------------------------------------
module accumulator_alu_execute_unit (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire aaeu_pkg::in_beat_t  s_payload,
    output logic                     m_valid,
    input  wire                      m_ready,
    output aaeu_pkg::out_beat_t      m_payload
);
    import aaeu_pkg::*;

    // input stage
    logic      in_valid_reg;
    in_beat_t  in_beat_reg;

    // architectural state
    arch_t     state_reg;
    arch_t     state_next;

    // result stage
    logic      m_valid_reg;
    out_beat_t m_payload_reg;
    out_beat_t m_payload_next;

    logic      out_free;
    logic      issue;

    // result register empties or drains this cycle
    assign out_free = ~m_valid_reg | m_ready;
    // input beat moves into the result register
    assign issue    = in_valid_reg & out_free;
    assign s_ready  = ~in_valid_reg | issue;

    aaeu_alu u_alu (
        .beat (in_beat_reg),
        .cur  (state_reg),
        .nxt  (state_next)
    );

    // result beat mirrors the state after the opcode
    assign m_payload_next.acc_out    = state_next.acc;
    assign m_payload_next.index_out  = state_next.idx;
    assign m_payload_next.neg_flag   = state_next.flags.n;
    assign m_payload_next.zero_flag  = state_next.flags.z;
    assign m_payload_next.carry_flag = state_next.flags.c;
    assign m_payload_next.ovf_flag   = state_next.flags.v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
            if (issue) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_beat_reg <= s_payload;
        end
        if (issue) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // a shown result always matches the live state
    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_payload_reg.acc_out == state_reg.acc)
                     && (m_payload_reg.index_out == state_reg.idx)
                     && (m_payload_reg.neg_flag == state_reg.flags.n)
                     && (m_payload_reg.zero_flag == state_reg.flags.z)
                     && (m_payload_reg.carry_flag == state_reg.flags.c)
                     && (m_payload_reg.ovf_flag == state_reg.flags.v))
        else $error("result beat differs from architectural state");

    // clear-all wipes A, X and flags
    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && (in_beat_reg.action == OP_CLR_ALL)) |=> (state_reg == '0))
        else $error("clear-all left state behind");

    // swap exchanges A and X and keeps the flags
    a_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && (in_beat_reg.action == OP_SWAP))
            |=> (state_reg.acc == $past(state_reg.idx))
             && (state_reg.idx == $past(state_reg.acc))
             && (state_reg.flags == $past(state_reg.flags)))
        else $error("swap did not exchange A and X");

endmodule
`default_nettype wire
